// ===== rtl/ssf_pkg.sv =====
// ----------------------------------------------------------------------------
// ssf_pkg: shared types and constants of the shortest-seek-first scheduler
// Sizes, error codes, register indexes and the structs between modules.
// ----------------------------------------------------------------------------
package ssf_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int CYL_BITS    = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CCOUNT_W    = CYL_BITS + 1;
  localparam int TOTAL_W     = 21;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;
  localparam int REG_W       = ADDR_W - 2;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_CYL_RANGE  = 2'd1,
    ERR_TABLE_FULL = 2'd2,
    ERR_HEAD_RANGE = 2'd3
  } err_e;

  typedef enum logic [REG_W-1:0] {
    REG_START_HEAD = 1'b0,
    REG_CYL_COUNT  = 1'b1
  } reg_e;

  typedef struct packed {
    logic [CYL_BITS-1:0] start_head;
    logic [CCOUNT_W-1:0] cyl_count;
  } cfg_t;

  typedef struct packed {
    logic                vld;
    logic [CYL_BITS-1:0] seek;
    logic [CYL_BITS-1:0] cyl;
  } best_t;

endpackage

// ===== rtl/ssf_intf.sv =====
// ----------------------------------------------------------------------------
// ssf_intf: request and result channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ssf_req_if;
  logic                         valid;
  logic                         ready;
  logic [ssf_pkg::CYL_BITS-1:0] cylinder;
  logic                         last_request;

  modport source (output valid, output cylinder, output last_request, input ready);
  modport sink   (input valid, input cylinder, input last_request, output ready);
endinterface

interface ssf_res_if;
  logic                         valid;
  logic                         ready;
  logic [ssf_pkg::CYL_BITS-1:0] serviced_cylinder;
  logic [ssf_pkg::CYL_BITS-1:0] step_distance;
  logic [ssf_pkg::TOTAL_W-1:0]  total_seek;
  logic [1:0]                   error_code;
  logic                         final_result;

  modport source (output valid, output serviced_cylinder, output step_distance,
                  output total_seek, output error_code, output final_result,
                  input ready);
  modport sink   (input valid, input serviced_cylinder, input step_distance,
                  input total_seek, input error_code, input final_result,
                  output ready);
endinterface

// ===== rtl/ssf_cfg.sv =====
// ----------------------------------------------------------------------------
// ssf_cfg: configuration registers
// APB-style write/read of start head and cylinder count.
// ----------------------------------------------------------------------------
module ssf_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssf_pkg::ADDR_W-1:0]  paddr,
  input  logic [ssf_pkg::DATA_W-1:0]  pwdata,
  output logic [ssf_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output ssf_pkg::cfg_t               cfg_o
);
  import ssf_pkg::*;

  cfg_t cfg_q;
  reg_e reg_sel;
  logic wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_head <= '0;
      cfg_q.cyl_count  <= CCOUNT_W'(1 << CYL_BITS);
    end else if (wr_en) begin
      case (reg_sel)
        REG_START_HEAD: cfg_q.start_head <= pwdata[CYL_BITS-1:0];
        REG_CYL_COUNT:  cfg_q.cyl_count  <= pwdata[CCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_START_HEAD: prdata = DATA_W'(cfg_q.start_head);
      REG_CYL_COUNT:  prdata = DATA_W'(cfg_q.cyl_count);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/ssf_req_table.sv =====
// ----------------------------------------------------------------------------
// ssf_req_table: request cylinder memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssf_req_table (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [ssf_pkg::IDX_W-1:0]    wr_addr_i,
  input  logic [ssf_pkg::CYL_BITS-1:0] wr_data_i,
  input  logic                         rd_en_i,
  input  logic [ssf_pkg::IDX_W-1:0]    rd_addr_i,
  output logic [ssf_pkg::CYL_BITS-1:0] rd_data_o
);
  import ssf_pkg::*;

  logic [CYL_BITS-1:0] mem_q [QUEUE_DEPTH];
  logic [CYL_BITS-1:0] rd_data_q;

  assign rd_data_o = rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

endmodule

// ===== rtl/ssf_seek_unit.sv =====
// ----------------------------------------------------------------------------
// ssf_seek_unit: shared seek distance and compare unit
// Computes |cylinder - head| and decides whether it beats the current best.
// ----------------------------------------------------------------------------
module ssf_seek_unit (
  input  logic [ssf_pkg::CYL_BITS-1:0] head_i,
  input  logic [ssf_pkg::CYL_BITS-1:0] cyl_i,
  input  ssf_pkg::best_t               best_i,
  output logic [ssf_pkg::CYL_BITS-1:0] dist_o,
  output logic                         better_o
);
  import ssf_pkg::*;

  assign dist_o = (cyl_i >= head_i) ? (cyl_i - head_i) : (head_i - cyl_i);

  // strict compare keeps the earliest loaded entry on a full tie
  assign better_o = !best_i.vld || (dist_o < best_i.seek) ||
                    ((dist_o == best_i.seek) && (cyl_i < best_i.cyl));

endmodule

// ===== rtl/shortest_seek_first_scheduler_core.sv =====
// Load: one request word per cycle while in the load state; each serviced
// request of a batch then takes a full table scan through the single read
// port and the shared seek unit, and waits for a free result slot.
// An error batch gives its single result after the last word is taken.
// Reset (async, active low) clears the sequencer, pending bits and counters;
// table contents stay undefined and are only read after being written.
// ----------------------------------------------------------------------------
// shortest_seek_first_scheduler_core: shortest-seek-first disk scheduler
// Loads a batch of request cylinders, then services the nearest one each pass.
// ----------------------------------------------------------------------------
module shortest_seek_first_scheduler_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ssf_req_if.sink                     req_i,
  ssf_res_if.source                   res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssf_pkg::ADDR_W-1:0]  paddr,
  input  logic [ssf_pkg::DATA_W-1:0]  pwdata,
  output logic [ssf_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import ssf_pkg::*;

  typedef enum logic [1:0] {
    S_LOAD,
    S_SCAN,
    S_EMIT,
    S_ERR
  } state_e;

  state_e              state_q;
  cfg_t                cfg;
  logic [CNT_W-1:0]    count_q;
  logic [CNT_W-1:0]    remaining_q;
  logic [CNT_W-1:0]    scan_idx_q;
  err_e                err_q;
  err_e                err_next;
  logic [QUEUE_DEPTH-1:0] pend_q;
  logic [CYL_BITS-1:0] head_q;
  logic [TOTAL_W-1:0]  total_q;
  logic [TOTAL_W-1:0]  total_sum;
  logic                cmp_vld_q;
  logic [IDX_W-1:0]    cmp_idx_q;
  best_t               best_q;
  logic [IDX_W-1:0]    best_idx_q;

  logic                res_vld_q;
  logic [CYL_BITS-1:0] res_cyl_q;
  logic [CYL_BITS-1:0] res_dist_q;
  logic [TOTAL_W-1:0]  res_total_q;
  err_e                res_err_q;
  logic                res_fin_q;

  logic                accept;
  logic                full;
  logic                cyl_bad;
  logic                head_bad;
  logic                store;
  logic                issue;
  logic [CYL_BITS-1:0] rd_data;
  logic [CYL_BITS-1:0] seek_dist;
  logic                better;
  logic                take;
  logic                slot_free;
  logic                res_load;

  ssf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign req_i.ready = (state_q == S_LOAD);
  assign accept      = req_i.valid && req_i.ready;
  assign full        = (count_q == CNT_W'(QUEUE_DEPTH));
  assign cyl_bad     = ({1'b0, req_i.cylinder} >= cfg.cyl_count);
  assign head_bad    = ({1'b0, cfg.start_head} >= cfg.cyl_count);
  assign store       = (err_q == ERR_NONE) && !full && !cyl_bad;

  // first error wins; table full is checked before range
  always_comb begin
    if (err_q != ERR_NONE) begin
      err_next = err_q;
    end else if (full) begin
      err_next = ERR_TABLE_FULL;
    end else if (cyl_bad) begin
      err_next = ERR_CYL_RANGE;
    end else begin
      err_next = ERR_NONE;
    end
  end

  assign issue = (state_q == S_SCAN) && (scan_idx_q < count_q);

  ssf_req_table u_table (
    .clk_i     (clk_i),
    .wr_en_i   (accept && store),
    .wr_addr_i (count_q[IDX_W-1:0]),
    .wr_data_i (req_i.cylinder),
    .rd_en_i   (issue),
    .rd_addr_i (scan_idx_q[IDX_W-1:0]),
    .rd_data_o (rd_data)
  );

  ssf_seek_unit u_seek (
    .head_i   (head_q),
    .cyl_i    (rd_data),
    .best_i   (best_q),
    .dist_o   (seek_dist),
    .better_o (better)
  );

  assign take      = cmp_vld_q && pend_q[cmp_idx_q] && better;
  assign slot_free = !res_vld_q || res_o.ready;
  assign res_load  = slot_free && ((state_q == S_EMIT) || (state_q == S_ERR));
  assign total_sum = total_q + TOTAL_W'(best_q.seek);

  assign res_o.valid             = res_vld_q;
  assign res_o.serviced_cylinder = res_cyl_q;
  assign res_o.step_distance     = res_dist_q;
  assign res_o.total_seek        = res_total_q;
  assign res_o.error_code        = res_err_q;
  assign res_o.final_result      = res_fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      remaining_q <= '0;
      scan_idx_q  <= '0;
      err_q       <= ERR_NONE;
      pend_q      <= '0;
      head_q      <= '0;
      total_q     <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      best_q      <= '0;
      best_idx_q  <= '0;
      res_vld_q   <= 1'b0;
      res_cyl_q   <= '0;
      res_dist_q  <= '0;
      res_total_q <= '0;
      res_err_q   <= ERR_NONE;
      res_fin_q   <= 1'b0;
    end else begin
      if (res_load) begin
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (accept) begin
            if (store) begin
              pend_q[count_q[IDX_W-1:0]] <= 1'b1;
              count_q <= count_q + CNT_W'(1);
            end
            if (req_i.last_request && (head_bad || (err_next != ERR_NONE))) begin
              err_q   <= head_bad ? ERR_HEAD_RANGE : err_next;
              state_q <= S_ERR;
            end else begin
              err_q <= err_next;
              if (req_i.last_request) begin
                head_q      <= cfg.start_head;
                total_q     <= '0;
                remaining_q <= count_q + CNT_W'(1);
                scan_idx_q  <= '0;
                cmp_vld_q   <= 1'b0;
                best_q      <= '0;
                state_q     <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          cmp_vld_q <= issue;
          cmp_idx_q <= scan_idx_q[IDX_W-1:0];
          if (issue) begin
            scan_idx_q <= scan_idx_q + CNT_W'(1);
          end
          if (take) begin
            best_q.vld  <= 1'b1;
            best_q.seek <= seek_dist;
            best_q.cyl  <= rd_data;
            best_idx_q  <= cmp_idx_q;
          end
          // drain the read pipe before picking
          if (!issue && !cmp_vld_q) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            res_cyl_q   <= best_q.cyl;
            res_dist_q  <= best_q.seek;
            res_total_q <= total_sum;
            res_err_q   <= ERR_NONE;
            res_fin_q   <= (remaining_q == CNT_W'(1));
            total_q     <= total_sum;
            head_q      <= best_q.cyl;
            remaining_q <= remaining_q - CNT_W'(1);
            if (remaining_q == CNT_W'(1)) begin
              count_q <= '0;
              err_q   <= ERR_NONE;
              pend_q  <= '0;
              state_q <= S_LOAD;
            end else begin
              pend_q[best_idx_q] <= 1'b0;
              scan_idx_q <= '0;
              best_q     <= '0;
              state_q    <= S_SCAN;
            end
          end
        end
        S_ERR: begin
          if (slot_free) begin
            res_cyl_q   <= '0;
            res_dist_q  <= '0;
            res_total_q <= '0;
            res_err_q   <= err_q;
            res_fin_q   <= 1'b1;
            count_q     <= '0;
            err_q       <= ERR_NONE;
            pend_q      <= '0;
            total_q     <= '0;
            state_q     <= S_LOAD;
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// ===== tb/sv/tb_shortest_seek_first_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// tb_shortest_seek_first_scheduler_core: self-checking bench of the scheduler
// Streams request batches under varying head and disk-size settings and
// traffic pacing, predicts each serviced cylinder, seek step, running total
// and error word in step with the accepted requests, and checks every result
// word in order.
// ----------------------------------------------------------------------------
module tb_shortest_seek_first_scheduler_core;
  import ssf_pkg::*;

  typedef struct packed {
    logic [CYL_BITS-1:0] cyl;
    logic                last;
  } req_word_t;

  typedef struct packed {
    logic [CYL_BITS-1:0] cyl;
    logic [CYL_BITS-1:0] step;
    logic [TOTAL_W-1:0]  total;
    err_e                err;
    logic                fin;
  } seek_res_t;

  typedef enum {PACE_FULL, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} pace_e;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  ssf_req_if req_if ();
  ssf_res_if res_if ();

  shortest_seek_first_scheduler_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // scheduler image: settings and batch state
  logic [CYL_BITS-1:0] cfg_start_head;
  logic [CCOUNT_W-1:0] cfg_cyl_count;
  logic [CYL_BITS-1:0] req_table [QUEUE_DEPTH];
  logic                req_pending [QUEUE_DEPTH];
  int unsigned         req_loaded;
  err_e                batch_err;

  req_word_t   word_q[$];
  seek_res_t   due_results[$];
  req_word_t   next_word;
  pace_e       pace;
  logic        word_taken;
  int unsigned words_queued;
  int unsigned words_taken;
  int unsigned phase_words;
  int unsigned mismatches;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void clear_batch();
    for (int i = 0; i < QUEUE_DEPTH; i++) req_pending[i] = 1'b0;
    req_loaded = 0;
    batch_err  = ERR_NONE;
  endfunction

  // Load one request; on the last one of a batch, queue every pick or the error word.
  function automatic void schedule_word(input logic [CYL_BITS-1:0] cyl, input logic last);
    int                  best;
    int unsigned         near_gap;
    int unsigned         best_cyl;
    int unsigned         c;
    int unsigned         d;
    int unsigned         total;
    logic [CYL_BITS-1:0] head;
    seek_res_t           r;
    if (batch_err == ERR_NONE) begin
      if (req_loaded >= QUEUE_DEPTH) begin
        batch_err = ERR_TABLE_FULL;
      end else if ({1'b0, cyl} >= cfg_cyl_count) begin
        batch_err = ERR_CYL_RANGE;
      end else begin
        req_table[req_loaded]   = cyl;
        req_pending[req_loaded] = 1'b1;
        req_loaded++;
      end
    end
    if (!last) return;
    r = '0;
    if ({1'b0, cfg_start_head} >= cfg_cyl_count || batch_err != ERR_NONE) begin
      r.err = ({1'b0, cfg_start_head} >= cfg_cyl_count) ? ERR_HEAD_RANGE : batch_err;
      r.fin = 1'b1;
      due_results.push_back(r);
      clear_batch();
      return;
    end
    head  = cfg_start_head;
    total = 0;
    for (int left = req_loaded; left > 0; left--) begin
      best     = -1;
      near_gap = 0;
      best_cyl = 0;
      for (int i = 0; i < req_loaded; i++) begin
        if (req_pending[i]) begin
          c = 32'(req_table[i]);
          d = (c >= head) ? c - head : head - c;
          // nearest wins, then the lower cylinder, then the earlier entry
          if (best < 0 || d < near_gap || (d == near_gap && c < best_cyl)) begin
            best     = i;
            near_gap = d;
            best_cyl = c;
          end
        end
      end
      req_pending[best] = 1'b0;
      total += near_gap;
      head   = best_cyl[CYL_BITS-1:0];
      r.cyl   = best_cyl[CYL_BITS-1:0];
      r.step  = near_gap[CYL_BITS-1:0];
      r.total = total[TOTAL_W-1:0];
      r.err   = ERR_NONE;
      r.fin   = (left == 1);
      due_results.push_back(r);
    end
    clear_batch();
  endfunction

  function automatic void check_result();
    seek_res_t want;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result word cyl=%0d dist=%0d total=%0d err=%0d fin=%0d",
               $time, res_if.serviced_cylinder, res_if.step_distance, res_if.total_seek,
               res_if.error_code, res_if.final_result);
      mismatches++;
      return;
    end
    want = due_results.pop_front();
    if (res_if.serviced_cylinder !== want.cyl) begin
      $display("%0t: serviced_cylinder expected %0d got %0d", $time, want.cyl,
               res_if.serviced_cylinder);
      mismatches++;
    end
    if (res_if.step_distance !== want.step) begin
      $display("%0t: step_distance expected %0d got %0d", $time, want.step,
               res_if.step_distance);
      mismatches++;
    end
    if (res_if.total_seek !== want.total) begin
      $display("%0t: total_seek expected %0d got %0d", $time, want.total, res_if.total_seek);
      mismatches++;
    end
    if (res_if.error_code !== want.err) begin
      $display("%0t: error_code expected %0d got %0d", $time, want.err, res_if.error_code);
      mismatches++;
    end
    if (res_if.final_result !== want.fin) begin
      $display("%0t: final_result expected %0d got %0d", $time, want.fin,
               res_if.final_result);
      mismatches++;
    end
  endfunction

  function automatic bit sender_idles();
    return (pace == PACE_SRC_IDLE && $urandom_range(99) < 62) ||
           (pace == PACE_BOTH && $urandom_range(99) < 38);
  endfunction

  function automatic bit sink_stalls();
    return (pace == PACE_SNK_STALL && $urandom_range(99) < 62) ||
           (pace == PACE_BOTH && $urandom_range(99) < 38);
  endfunction

  // sender and receiver pacing
  always @(negedge clk_i) begin
    if (rst_ni && (!req_if.valid || word_taken)) begin
      if (word_q.size() != 0 && !sender_idles()) begin
        next_word = word_q.pop_front();
        req_if.valid        <= 1'b1;
        req_if.cylinder     <= next_word.cyl;
        req_if.last_request <= next_word.last;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
    res_if.ready <= rst_ni && !sink_stalls();
  end

  always @(posedge clk_i) begin
    word_taken <= rst_ni && req_if.valid && req_if.ready;
    if (rst_ni && req_if.valid && req_if.ready) begin
      schedule_word(req_if.cylinder, req_if.last_request);
      words_taken++;
    end
    if (rst_ni && res_if.valid && res_if.ready) check_result();
  end

  task automatic write_reg(input reg_e idx, input int unsigned value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_START_HEAD: cfg_start_head = value[CYL_BITS-1:0];
      REG_CYL_COUNT:  cfg_cyl_count  = value[CCOUNT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_disk(input int unsigned head, input int unsigned count);
    write_reg(REG_START_HEAD, head);
    write_reg(REG_CYL_COUNT, count);
  endtask

  function automatic void push_word(input int unsigned cyl, input logic last);
    req_word_t w;
    w.cyl  = cyl[CYL_BITS-1:0];
    w.last = last;
    word_q.push_back(w);
    words_queued++;
    phase_words++;
  endfunction

  // hold off until every queued word is taken and every pick has come back
  task automatic drain();
    while (words_taken != words_queued || due_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  function automatic int unsigned legal_cyl();
    int          c;
    int unsigned top;
    top = (cfg_cyl_count == 0) ? 0 : cfg_cyl_count - 1;
    if ($urandom_range(2) == 0) begin
      // cluster around the head to force equal distances
      c = int'(cfg_start_head) + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(6));
      if (c < 0) c = 0;
      if (c > int'(top)) c = top;
      return c;
    end
    return $urandom_range(top);
  endfunction

  function automatic void random_batch();
    int unsigned kind;
    int unsigned n;
    int unsigned bad_at;
    int unsigned cyl;
    kind   = $urandom_range(99);
    n      = ($urandom_range(9) == 0) ? QUEUE_DEPTH : $urandom_range(1, 10);
    if (kind >= 92) n = $urandom_range(QUEUE_DEPTH + 1, QUEUE_DEPTH + 3);
    bad_at = (kind >= 78 && kind < 92) ? $urandom_range(n - 1) : n;
    for (int i = 0; i < n; i++) begin
      cyl = legal_cyl();
      if (i == bad_at && cfg_cyl_count <= 65535) cyl = $urandom_range(65535, cfg_cyl_count);
      if (kind >= 72 && kind < 78) cyl = $urandom_range(65535);
      push_word(cyl, i == n - 1);
    end
  endfunction

  initial begin
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    req_if.valid        = 1'b0;
    req_if.cylinder     = '0;
    req_if.last_request = 1'b0;
    res_if.ready        = 1'b0;
    word_taken          = 1'b0;
    words_queued        = 0;
    words_taken         = 0;
    mismatches          = 0;
    pace                = PACE_FULL;
    cfg_start_head      = '0;
    cfg_cyl_count       = 17'd65536;
    clear_batch();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: head at 0, full disk; equal cylinders
    push_word(0, 1'b1);
    push_word(65535, 1'b0);
    push_word(0, 1'b0);
    push_word(0, 1'b1);
    push_word(32768, 1'b0);
    push_word(1, 1'b0);
    push_word(65534, 1'b1);
    drain();

    // tie on distance goes low; out-of-range word; table overflow beats range
    set_disk(100, 200);
    push_word(90, 1'b0);
    push_word(110, 1'b0);
    push_word(150, 1'b1);
    push_word(5, 1'b0);
    push_word(200, 1'b0);
    push_word(7, 1'b1);
    push_word(199, 1'b0);
    push_word(0, 1'b1);
    for (int i = 0; i < QUEUE_DEPTH; i++) push_word(i * 6, 1'b0);
    push_word(250, 1'b1);
    drain();

    set_disk(65535, 65536);
    push_word(0, 1'b0);
    push_word(65535, 1'b1);
    drain();

    // head outside the disk overrides a recorded range error
    set_disk(10, 1);
    push_word(0, 1'b0);
    push_word(5, 1'b1);
    drain();

    set_disk(0, 1);
    push_word(0, 1'b0);
    push_word(0, 1'b0);
    push_word(0, 1'b1);
    push_word(1, 1'b1);
    drain();

    // empty disk: every word and the head are out of range
    set_disk(0, 0);
    push_word(0, 1'b1);
    drain();

    for (int p = 0; p < 8; p++) begin
      pace = pace_e'(p % 4);
      case (p)
        0: set_disk(0, 65536);
        5: set_disk(65535, 65536);
        6: set_disk(0, 1);
        default: begin
          int unsigned count;
          count = $urandom_range(1) ? 65536 : $urandom_range(2048, 2);
          set_disk($urandom_range(count - 1), count);
        end
      endcase
      phase_words = 0;
      while (phase_words < 10) random_batch();
      drain();
    end

    repeat (40) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ssf_pkg.sv
rtl/ssf_intf.sv
rtl/ssf_cfg.sv
rtl/ssf_req_table.sv
rtl/ssf_seek_unit.sv
rtl/shortest_seek_first_scheduler_core.sv
tb/sv/tb_shortest_seek_first_scheduler_core.sv
